/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the boost PFC controller.
// Users must provide clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define BPFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Plain condition that must be true on every clock edge outside reset.
`define BPFC_ASSERT_ALWAYS(lbl, cond, msg) \
  `BPFC_ASSERT(lbl, (cond), msg)

`endif

/* rtl/core/bpfc_pkg.sv */
// Shared types, constants and saturating arithmetic helpers for the
// boost PFC current-mode controller. No dependencies.
`default_nettype none

package bpfc_pkg;

  localparam int VIN_W   = 44;
  localparam int IIN_W   = 42;
  localparam int TS_W    = 33;
  localparam int DUTY_W  = 32;
  localparam int VOUT_W  = 44;
  localparam int AMP_W   = 41;
  localparam int VREG_W  = 43;
  localparam int GAIN_W  = 49;
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 6;

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PEAK_NUM = 64'd141421356;
  localparam logic [63:0] PEAK_DEN = 64'd100000000;

  typedef enum logic [2:0] {
    REG_VOUT_REF  = 3'd0,
    REG_VIN_RMS   = 3'd1,
    REG_POUT      = 3'd2,
    REG_VKP       = 3'd3,
    REG_VKI       = 3'd4,
    REG_CKP       = 3'd5,
    REG_CKI       = 3'd6,
    REG_INV_COUT  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [VREG_W-1:0] vout_ref;
    logic [VREG_W-1:0] vin_rms;
    logic [GAIN_W-1:0] pout;
    logic [GAIN_W-1:0] vkp;
    logic [GAIN_W-1:0] vki;
    logic [GAIN_W-1:0] ckp;
    logic [GAIN_W-1:0] cki;
    logic [GAIN_W-1:0] inv_cout;
    logic              vref_wr;
    logic [VREG_W-1:0] vref_new;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic        div;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
  } muldiv_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } muldiv_rsp_t;

  function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SMAX)) return SMAX;
    if (s < -65'(SMAX)) return -SMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(SMAX)) return SMAX;
    if (s < -65'(SMAX)) return -SMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clampv(logic signed [63:0] x, logic signed [63:0] lo,
                                                logic signed [63:0] hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] x);
    logic signed [63:0] n;
    n = -x;
    return x[63] ? n : x;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bpfc_if.sv */
// Stream interfaces for the sample words in and the control words out.
// Depends on bpfc_pkg for field widths.
`default_nettype none

interface bpfc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [bpfc_pkg::VIN_W-1:0] vin_sample;
  logic signed [bpfc_pkg::IIN_W-1:0] iin_sample;
  logic        [bpfc_pkg::TS_W-1:0]  sample_period;

  modport source (output valid, vin_sample, iin_sample, sample_period, input ready);
  modport sink (input valid, vin_sample, iin_sample, sample_period, output ready);
endinterface

interface bpfc_out_if;
  logic                               valid;
  logic                               ready;
  logic        [bpfc_pkg::DUTY_W-1:0] duty;
  logic signed [bpfc_pkg::VOUT_W-1:0] model_vout;
  logic        [bpfc_pkg::AMP_W-1:0]  current_amplitude;
  logic        [bpfc_pkg::AMP_W-1:0]  current_reference;
  logic                               step_error;

  modport source (output valid, duty, model_vout, current_amplitude, current_reference,
                  step_error, input ready);
  modport sink (input valid, duty, model_vout, current_amplitude, current_reference,
                step_error, output ready);
endinterface

`default_nettype wire

/* rtl/core/bpfc_regs.sv */
// APB register file holding the loop setpoints, gains and plant constants.
// Depends on bpfc_pkg.
`default_nettype none

module bpfc_regs #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bpfc_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [bpfc_pkg::CFG_DW-1:0]   pwdata,
  output      logic [bpfc_pkg::CFG_DW-1:0]   prdata,
  output      logic                          pready,
  output      bpfc_pkg::cfg_t                cfg_o
);

  localparam logic [63:0] VREF_RST = 64'd400 << FRAC_BITS;
  localparam logic [63:0] VRMS_RST = 64'd230 << FRAC_BITS;
  localparam logic [63:0] POUT_RST = 64'd1000 << FRAC_BITS;
  localparam logic [63:0] COUT_RST = 64'd2127 << FRAC_BITS;

  logic [bpfc_pkg::VREG_W-1:0] vref_q, vrms_q;
  logic [bpfc_pkg::GAIN_W-1:0] pout_q, vkp_q, vki_q, ckp_q, cki_q, cout_q;
  logic                        wr;
  bpfc_pkg::reg_idx_e          idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = bpfc_pkg::reg_idx_e'(paddr[5:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q <= VREF_RST[bpfc_pkg::VREG_W-1:0];
      vrms_q <= VRMS_RST[bpfc_pkg::VREG_W-1:0];
      pout_q <= POUT_RST[bpfc_pkg::GAIN_W-1:0];
      vkp_q  <= '0;
      vki_q  <= '0;
      ckp_q  <= '0;
      cki_q  <= '0;
      cout_q <= COUT_RST[bpfc_pkg::GAIN_W-1:0];
    end else if (wr) begin
      case (idx)
        bpfc_pkg::REG_VOUT_REF: vref_q <= pwdata[bpfc_pkg::VREG_W-1:0];
        bpfc_pkg::REG_VIN_RMS:  vrms_q <= pwdata[bpfc_pkg::VREG_W-1:0];
        bpfc_pkg::REG_POUT:     pout_q <= pwdata[bpfc_pkg::GAIN_W-1:0];
        bpfc_pkg::REG_VKP:      vkp_q  <= pwdata[bpfc_pkg::GAIN_W-1:0];
        bpfc_pkg::REG_VKI:      vki_q  <= pwdata[bpfc_pkg::GAIN_W-1:0];
        bpfc_pkg::REG_CKP:      ckp_q  <= pwdata[bpfc_pkg::GAIN_W-1:0];
        bpfc_pkg::REG_CKI:      cki_q  <= pwdata[bpfc_pkg::GAIN_W-1:0];
        bpfc_pkg::REG_INV_COUT: cout_q <= pwdata[bpfc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bpfc_pkg::REG_VOUT_REF: prdata = 64'(vref_q);
      bpfc_pkg::REG_VIN_RMS:  prdata = 64'(vrms_q);
      bpfc_pkg::REG_POUT:     prdata = 64'(pout_q);
      bpfc_pkg::REG_VKP:      prdata = 64'(vkp_q);
      bpfc_pkg::REG_VKI:      prdata = 64'(vki_q);
      bpfc_pkg::REG_CKP:      prdata = 64'(ckp_q);
      bpfc_pkg::REG_CKI:      prdata = 64'(cki_q);
      bpfc_pkg::REG_INV_COUT: prdata = 64'(cout_q);
      default:                prdata = '0;
    endcase
  end

  // The model voltage is reloaded in the same cycle the reference is written.
  always_comb begin
    cfg_o.vout_ref = vref_q;
    cfg_o.vin_rms  = vrms_q;
    cfg_o.pout     = pout_q;
    cfg_o.vkp      = vkp_q;
    cfg_o.vki      = vki_q;
    cfg_o.ckp      = ckp_q;
    cfg_o.cki      = cki_q;
    cfg_o.inv_cout = cout_q;
    cfg_o.vref_wr  = wr && (idx == bpfc_pkg::REG_VOUT_REF);
    cfg_o.vref_new = pwdata[bpfc_pkg::VREG_W-1:0];
  end

endmodule

`default_nettype wire

/* rtl/core/bpfc_muldiv.sv */
// Shared multiply / multiply-divide unit: floor(a*b >> FRAC_BITS) or
// floor(a*b/d), saturated to the signed 64-bit maximum. Depends on bpfc_pkg.
`default_nettype none

module bpfc_muldiv #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bpfc_pkg::muldiv_req_t req_i,
  output      bpfc_pkg::muldiv_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_DONE = 4'b1000
  } ustate_e;

  ustate_e      st_q;
  logic [5:0]   cnt_q;
  logic         div_q;
  logic [63:0]  a_q, b_q, d_q, rem_q, lo_q, q_q;
  logic [127:0] acc_q;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh, acc_sum, shifted;
  logic [63:0]  mul_res, rem_next;
  logic [64:0]  trial;
  logic         fits, hi_sat;

  // One 32x32 partial product per cycle; four such products form the full product.
  always_comb begin
    a_half  = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    b_half  = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp      = 64'(a_half) * 64'(b_half);
    case (cnt_q[1:0])
      2'b00:        pp_sh = {64'd0, pp};
      2'b01, 2'b10: pp_sh = {32'd0, pp, 32'd0};
      default:      pp_sh = {pp, 64'd0};
    endcase
    acc_sum = acc_q + pp_sh;
    shifted = acc_sum >> FRAC_BITS;
    mul_res = (|shifted[127:63]) ? bpfc_pkg::SMAX : shifted[63:0];
    hi_sat  = acc_sum[127:64] >= d_q;
    trial    = {rem_q, lo_q[63]};
    fits     = trial >= {1'b0, d_q};
    rem_next = fits ? 64'(trial - {1'b0, d_q}) : trial[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= U_IDLE;
      cnt_q <= '0;
    end else begin
      case (st_q)
        U_IDLE: begin
          if (req_i.start) begin
            st_q  <= U_MUL;
            cnt_q <= '0;
          end
        end
        U_MUL: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q[1:0] == 2'd3) begin
            if (!div_q || hi_sat) begin
              st_q <= U_DONE;
            end else begin
              st_q  <= U_DIV;
              cnt_q <= '0;
            end
          end
        end
        U_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) st_q <= U_DONE;
        end
        U_DONE:  st_q <= U_IDLE;
        default: st_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      U_IDLE: begin
        if (req_i.start) begin
          a_q   <= req_i.a;
          b_q   <= req_i.b;
          d_q   <= req_i.d;
          div_q <= req_i.div;
          acc_q <= '0;
        end
      end
      U_MUL: begin
        acc_q <= acc_sum;
        if (cnt_q[1:0] == 2'd3) begin
          if (!div_q) begin
            q_q <= mul_res;
          end else if (hi_sat) begin
            q_q <= bpfc_pkg::SMAX;
          end else begin
            rem_q <= acc_sum[127:64];
            lo_q  <= acc_sum[63:0];
            q_q   <= '0;
          end
        end
      end
      U_DIV: begin
        rem_q <= rem_next;
        lo_q  <= {lo_q[62:0], 1'b0};
        q_q   <= {q_q[62:0], fits};
      end
      default: ;
    endcase
  end

  assign rsp_o.done = (st_q == U_DONE);
  assign rsp_o.q    = q_q[63] ? bpfc_pkg::SMAX : q_q;

endmodule

`default_nettype wire

/* rtl/core/boost_pfc_current_mode_control.sv */
// Top level of the boost PFC average-current-mode controller: sequencer,
// loop state and output register. Uses bpfc_pkg, bpfc_if, bpfc_regs, bpfc_muldiv.
//
//   channel  | direction | contents
//   in_i     | sink      | vin_sample, iin_sample, sample_period
//   out_o    | source    | duty, model_vout, current_amplitude, current_reference,
//            |           | step_error
//   APB      | slave     | eight 64-bit setpoint and gain registers at 8*index
//
// A word with a nonzero period runs eleven multiplies and four multiply-divides
// through the one shared unit; a zero-period word goes straight to the output
// state. The input is ready only while the sequencer is idle. Reset loads the
// register defaults and clears both integrators. A stalled output holds the
// sequencer in its final state.
`default_nettype none

`include "assert_macros.svh"

module boost_pfc_current_mode_control #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  bpfc_in_if.sink                          in_i,
  bpfc_out_if.source                       out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bpfc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [bpfc_pkg::CFG_DW-1:0] pwdata,
  output      logic [bpfc_pkg::CFG_DW-1:0] prdata,
  output      logic                        pready
);

  localparam logic signed [63:0] ONE      = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] EPS      = (64'd1 << FRAC_BITS) / 64'd1000000000000;
  localparam logic signed [63:0] D95      = (64'd19 << FRAC_BITS) / 64'd20;
  localparam logic signed [63:0] VLIM     = 64'sd1024 <<< FRAC_BITS;
  localparam logic signed [63:0] ALIM     = 64'sd256 <<< FRAC_BITS;
  localparam logic signed [63:0] VINT_LIM = 64'sd10 <<< FRAC_BITS;
  localparam logic signed [63:0] CINT_LIM = 64'sd5 <<< FRAC_BITS;
  localparam logic signed [63:0] VM_RST   = 64'sd400 <<< FRAC_BITS;
  localparam int SH_R = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
  localparam int SH_L = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;

  typedef enum logic [16:0] {
    S_IDLE = 17'b00000000000000001,
    S_VI   = 17'b00000000000000010,
    S_VP   = 17'b00000000000000100,
    S_VIG  = 17'b00000000000001000,
    S_PK   = 17'b00000000000010000,
    S_SH   = 17'b00000000000100000,
    S_IR   = 17'b00000000001000000,
    S_CI   = 17'b00000000010000000,
    S_CP   = 17'b00000000100000000,
    S_CIG  = 17'b00000001000000000,
    S_FF   = 17'b00000010000000000,
    S_IL   = 17'b00000100000000000,
    S_M1   = 17'b00001000000000000,
    S_M2   = 17'b00010000000000000,
    S_M3   = 17'b00100000000000000,
    S_DV   = 17'b01000000000000000,
    S_OUT  = 17'b10000000000000000
  } seq_state_e;

  bpfc_pkg::cfg_t        cfg;
  bpfc_pkg::muldiv_req_t req;
  bpfc_pkg::muldiv_rsp_t rsp;

  bpfc_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpfc_muldiv #(.FRAC_BITS(FRAC_BITS)) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  seq_state_e state_q, state_nxt;
  logic       issued_q, err_q;
  logic signed [bpfc_pkg::VIN_W-1:0] vin_q;
  logic signed [bpfc_pkg::IIN_W-1:0] iin_q;
  logic        [bpfc_pkg::TS_W-1:0]  ts_q;
  logic signed [63:0] vm_q, vint_q, cint_q;
  logic signed [63:0] p_q, amp_q, vpeak_q, shape_q, iref_q, raw_q, duty_q;
  logic signed [63:0] iload_q, m1_q, m2_q;

  logic                        out_valid_q, out_err_q;
  logic [bpfc_pkg::DUTY_W-1:0] out_duty_q;
  logic [bpfc_pkg::VOUT_W-1:0] out_vm_q;
  logic [bpfc_pkg::AMP_W-1:0]  out_amp_q, out_ref_q;

  logic in_acc, out_free, op_state, op_div, op_raw, op_skip, special, neg, step_done;
  logic zero_acc;
  logic signed [63:0] vin64, iin64, ts64, vabs, verr, ierr, vden, vref_load;
  logic signed [63:0] op_a, op_b, spec_res, q_s, res;
  logic [63:0]        dq64;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;
  assign zero_acc   = in_acc && (in_i.sample_period == '0) && !cfg.vref_wr;

  always_comb begin
    vin64 = 64'(vin_q);
    iin64 = 64'(iin_q);
    ts64  = signed'(64'(ts_q));
    vabs  = vin64[63] ? -vin64 : vin64;
    verr  = bpfc_pkg::ssub(signed'(64'(cfg.vout_ref)), vm_q);
    ierr  = bpfc_pkg::ssub(iref_q, iin64);
    vden  = bpfc_pkg::sadd(vm_q, EPS);
    vref_load = (signed'(64'(cfg.vref_new)) > VLIM) ? VLIM : signed'(64'(cfg.vref_new));
  end

  // Operand selection for the step in progress.
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    op_div   = 1'b0;
    op_raw   = 1'b0;
    op_skip  = 1'b0;
    op_state = 1'b1;
    case (state_q)
      S_VI:  begin op_a = verr;                            op_b = ts64;    end
      S_VP:  begin op_a = signed'(64'(cfg.vkp));           op_b = verr;    end
      S_VIG: begin op_a = signed'(64'(cfg.vki));           op_b = vint_q;  end
      S_PK:  begin
        op_a   = signed'(64'(cfg.vin_rms));
        op_b   = signed'(bpfc_pkg::PEAK_NUM);
        op_raw = 1'b1;
      end
      S_SH:  begin
        op_a    = vabs;
        op_b    = vpeak_q;
        op_div  = 1'b1;
        op_skip = !(vpeak_q > EPS);
      end
      S_IR:  begin op_a = amp_q;                           op_b = shape_q; end
      S_CI:  begin op_a = ierr;                            op_b = ts64;    end
      S_CP:  begin op_a = signed'(64'(cfg.ckp));           op_b = ierr;    end
      S_CIG: begin op_a = signed'(64'(cfg.cki));           op_b = cint_q;  end
      S_FF:  begin op_a = vabs;   op_b = vden;   op_div = 1'b1;            end
      S_IL:  begin op_a = signed'(64'(cfg.pout)); op_b = vden; op_div = 1'b1; end
      S_M1:  begin op_a = ONE - duty_q;                    op_b = iin64;   end
      S_M2:  begin op_a = m1_q;   op_b = signed'(64'(cfg.inv_cout));       end
      S_M3:  begin op_a = iload_q; op_b = signed'(64'(cfg.inv_cout));      end
      S_DV:  begin op_a = p_q;                             op_b = ts64;    end
      default: op_state = 1'b0;
    endcase

    // Zero-operand quotients (bar the raw peak step) never reach the shared unit.
    special  = op_skip || (op_div && (op_a == 64'sd0 || op_b == 64'sd0));
    spec_res = (op_skip || op_a == 64'sd0) ? 64'sd0 :
               (op_a[63] ? -bpfc_pkg::SMAX : bpfc_pkg::SMAX);

    req.start = op_state && !issued_q && !special;
    req.div   = op_div || op_raw;
    req.a     = op_raw ? 64'(op_a) : bpfc_pkg::mag(op_a);
    req.b     = op_raw ? 64'(op_b) : (op_div ? 64'(ONE) : bpfc_pkg::mag(op_b));
    req.d     = op_raw ? bpfc_pkg::PEAK_DEN : bpfc_pkg::mag(op_b);

    neg       = !op_raw && (op_a[63] != op_b[63]);
    q_s       = signed'(rsp.q);
    res       = special ? spec_res : (neg ? -q_s : q_s);
    step_done = op_state && (special || rsp.done);
  end

  always_comb begin
    state_nxt = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_nxt = (in_i.sample_period == '0) ? S_OUT : S_VI;
      S_VI:   if (step_done) state_nxt = S_VP;
      S_VP:   if (step_done) state_nxt = S_VIG;
      S_VIG:  if (step_done) state_nxt = S_PK;
      S_PK:   if (step_done) state_nxt = S_SH;
      S_SH:   if (step_done) state_nxt = S_IR;
      S_IR:   if (step_done) state_nxt = S_CI;
      S_CI:   if (step_done) state_nxt = S_CP;
      S_CP:   if (step_done) state_nxt = S_CIG;
      S_CIG:  if (step_done) state_nxt = S_FF;
      S_FF:   if (step_done) state_nxt = S_IL;
      S_IL:   if (step_done) state_nxt = S_M1;
      S_M1:   if (step_done) state_nxt = S_M2;
      S_M2:   if (step_done) state_nxt = S_M3;
      S_M3:   if (step_done) state_nxt = S_DV;
      S_DV:   if (step_done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      vm_q        <= VM_RST;
      vint_q      <= '0;
      cint_q      <= '0;
    end else begin
      state_q <= state_nxt;
      if (req.start) issued_q <= 1'b1;
      else if (rsp.done) issued_q <= 1'b0;

      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;

      if (cfg.vref_wr) vm_q <= vref_load;
      else if (state_q == S_DV && step_done)
        vm_q <= bpfc_pkg::clampv(bpfc_pkg::sadd(vm_q, res), -VLIM, VLIM);

      if (state_q == S_VI && step_done)
        vint_q <= bpfc_pkg::clampv(bpfc_pkg::sadd(vint_q, res), -VINT_LIM, VINT_LIM);
      if (state_q == S_CI && step_done)
        cint_q <= bpfc_pkg::clampv(bpfc_pkg::sadd(cint_q, res), -CINT_LIM, CINT_LIM);
    end
  end

  assign dq64 = (64'(duty_q) >> SH_R) << SH_L;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vin_q <= in_i.vin_sample;
      iin_q <= in_i.iin_sample;
      ts_q  <= in_i.sample_period;
      err_q <= (in_i.sample_period == '0);
    end
    if (step_done) begin
      case (state_q)
        S_VP:   p_q     <= res;
        S_VIG:  amp_q   <= bpfc_pkg::clampv(bpfc_pkg::sadd(p_q, res), 64'sd0, ALIM);
        S_PK:   vpeak_q <= res;
        S_SH:   shape_q <= (res > ONE) ? ONE : res;
        S_IR:   iref_q  <= res;
        S_CP:   p_q     <= res;
        S_CIG:  raw_q   <= bpfc_pkg::sadd(p_q, res);
        S_FF:   duty_q  <= bpfc_pkg::clampv(
                             bpfc_pkg::sadd(raw_q, bpfc_pkg::ssub(ONE, res)), 64'sd0, D95);
        S_IL:   iload_q <= res;
        S_M1:   m1_q    <= res;
        S_M2:   m2_q    <= res;
        S_M3:   p_q     <= bpfc_pkg::ssub(m2_q, res);
        default: ;
      endcase
    end
    if (state_q == S_OUT && out_free) begin
      out_err_q  <= err_q;
      out_vm_q   <= vm_q[bpfc_pkg::VOUT_W-1:0];
      out_duty_q <= err_q ? '0 : dq64[bpfc_pkg::DUTY_W-1:0];
      out_amp_q  <= err_q ? '0 : amp_q[bpfc_pkg::AMP_W-1:0];
      out_ref_q  <= err_q ? '0 : iref_q[bpfc_pkg::AMP_W-1:0];
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.duty              = out_duty_q;
  assign out_o.model_vout        = signed'(out_vm_q);
  assign out_o.current_amplitude = out_amp_q;
  assign out_o.current_reference = out_ref_q;
  assign out_o.step_error        = out_err_q;

  `BPFC_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == S_OUT), "early word")
  `BPFC_ASSERT(a_idle_no_op, (state_q == S_IDLE) |-> !issued_q, "unit busy while idle")
  `BPFC_ASSERT_ALWAYS(a_vint_bound, (vint_q <= VINT_LIM) && (vint_q >= -VINT_LIM), "vint range")
  `BPFC_ASSERT(a_err_keeps_vm, zero_acc |=> $stable(vm_q), "zero period changed model")

endmodule

`default_nettype wire
